// ===== rtl/core/bcp_pkg.sv =====
// bcp_pkg: shared types, widths and constants of the brightness centroid pointer.
// Used by bcp_ctrl, bcp_datapath and brightness_centroid_pointer; depends on nothing.
package bcp_pkg;

  localparam int unsigned MomW   = 46;
  localparam int unsigned TotW   = 34;
  localparam int unsigned NumW   = 54;          // dividend: moment shifted by eight
  localparam int unsigned RemW   = TotW + 1;
  localparam int unsigned OffW   = 27;          // signed Q8 offset
  localparam int unsigned M2W    = 53;
  localparam int unsigned MagW   = 27;
  localparam int unsigned DirW   = 10;          // signed Q8 unit part
  localparam int unsigned CorW   = 20;
  localparam int unsigned AngW   = 18;
  localparam int unsigned CntW   = 6;
  localparam int unsigned DivSteps  = NumW;
  localparam int unsigned SqrtSteps = 27;
  localparam int unsigned CorSteps  = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned DimCfgW = 13;
  localparam logic [15:0] LfsrMask = 16'hB400;
  localparam logic [CorW-1:0] CorX0 = CorW'(9949);

  typedef enum logic [1:0] {
    CFG_WIDTH = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DEAD_ZONE = 2'd2,
    CFG_SEED = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACC,
    CMD_DIV_LDX,
    CMD_DIV_LDY,
    CMD_DIV_LDUX,
    CMD_DIV_LDUY,
    CMD_DIV_STEP,
    CMD_ST_VX,
    CMD_ST_VY,
    CMD_SQ1,
    CMD_SQ2,
    CMD_SQRT_LD,
    CMD_SQRT_STEP,
    CMD_ST_UX,
    CMD_ST_UY,
    CMD_RND_LD,
    CMD_COR_STEP,
    CMD_ST_RDIR,
    CMD_PLACE
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [3:0] idx;   // CORDIC iteration
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic total_zero;
    logic below_dz;
    logic mag_zero;
  } sts_t;

  function automatic logic [AngW-1:0] atan_q14(input logic [3:0] i);
    logic [AngW-1:0] v;
    case (i)
      4'd0: v = AngW'(16384);
      4'd1: v = AngW'(9672);
      4'd2: v = AngW'(5110);
      4'd3: v = AngW'(2594);
      4'd4: v = AngW'(1302);
      4'd5: v = AngW'(652);
      4'd6: v = AngW'(326);
      4'd7: v = AngW'(163);
      4'd8: v = AngW'(81);
      4'd9: v = AngW'(41);
      4'd10: v = AngW'(20);
      4'd11: v = AngW'(10);
      4'd12: v = AngW'(5);
      4'd13: v = AngW'(3);
      default: v = AngW'(1);
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/bcp_ctrl.sv =====
// bcp_ctrl: sequencer of the pointer block; steps the datapath through accumulate,
// divide, square root, CORDIC and placement. Depends on bcp_pkg.
module bcp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_free_i,
  input  bcp_pkg::sts_t sts_i,
  output bcp_pkg::cmd_t cmd_o
);
  import bcp_pkg::*;

  typedef enum logic [4:0] {
    S_ACC, S_DXL, S_DX, S_VX, S_DYL, S_DY, S_VY, S_SQ1, S_SQ2, S_CMP,
    S_SRL, S_SR, S_MAG, S_UXL, S_UX, S_UXS, S_UYL, S_UY, S_UYS,
    S_RND, S_COR, S_RDIR, S_PLACE
  } state_e;

  state_e        state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_ACC);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + CntW'(1);
    cmd_o.op  = CMD_NONE;
    cmd_o.idx = cnt_q[3:0];
    case (state_q)
      S_ACC: begin
        cnt_d = '0;
        if (in_valid_i) begin
          cmd_o.op = CMD_ACC;
          if (sts_i.frame_end) state_d = S_DXL;
        end
      end
      S_DXL: begin
        cmd_o.op = CMD_DIV_LDX;
        cnt_d = '0;
        state_d = sts_i.total_zero ? S_RND : S_DX;
      end
      S_DX: begin
        cmd_o.op = CMD_DIV_STEP;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_VX;
      end
      S_VX: begin cmd_o.op = CMD_ST_VX; state_d = S_DYL; end
      S_DYL: begin cmd_o.op = CMD_DIV_LDY; cnt_d = '0; state_d = S_DY; end
      S_DY: begin
        cmd_o.op = CMD_DIV_STEP;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_VY;
      end
      S_VY: begin cmd_o.op = CMD_ST_VY; state_d = S_SQ1; end
      S_SQ1: begin cmd_o.op = CMD_SQ1; state_d = S_SQ2; end
      S_SQ2: begin cmd_o.op = CMD_SQ2; state_d = S_CMP; end
      S_CMP: state_d = sts_i.below_dz ? S_RND : S_SRL;
      S_SRL: begin cmd_o.op = CMD_SQRT_LD; cnt_d = '0; state_d = S_SR; end
      S_SR: begin
        cmd_o.op = CMD_SQRT_STEP;
        if (cnt_q == CntW'(SqrtSteps - 1)) state_d = S_MAG;
      end
      S_MAG: state_d = sts_i.mag_zero ? S_RND : S_UXL;
      S_UXL: begin cmd_o.op = CMD_DIV_LDUX; cnt_d = '0; state_d = S_UX; end
      S_UX: begin
        cmd_o.op = CMD_DIV_STEP;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_UXS;
      end
      S_UXS: begin cmd_o.op = CMD_ST_UX; state_d = S_UYL; end
      S_UYL: begin cmd_o.op = CMD_DIV_LDUY; cnt_d = '0; state_d = S_UY; end
      S_UY: begin
        cmd_o.op = CMD_DIV_STEP;
        if (cnt_q == CntW'(DivSteps - 1)) state_d = S_UYS;
      end
      S_UYS: begin cmd_o.op = CMD_ST_UY; state_d = S_PLACE; end
      S_RND: begin cmd_o.op = CMD_RND_LD; cnt_d = '0; state_d = S_COR; end
      S_COR: begin
        cmd_o.op = CMD_COR_STEP;
        if (cnt_q == CntW'(CorSteps - 1)) state_d = S_RDIR;
      end
      S_RDIR: begin cmd_o.op = CMD_ST_RDIR; state_d = S_PLACE; end
      S_PLACE: begin
        if (out_free_i) begin
          cmd_o.op = CMD_PLACE;
          state_d = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/bcp_datapath.sv =====
// bcp_datapath: moment accumulators, shared restoring divider, square root, CORDIC
// and pointer placement of the pointer block. Depends on bcp_pkg.
module bcp_datapath #(
  parameter int unsigned CNT_W = 12,
  parameter int unsigned DIM_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bcp_pkg::cmd_t    cmd_i,
  output bcp_pkg::sts_t    sts_o,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic [DIM_W-1:0] width_i,
  input  logic [DIM_W-1:0] height_i,
  input  logic [7:0]       dead_zone_i,
  input  logic             seed_we_i,
  input  logic [15:0]      seed_i,
  output logic [11:0]      pointer_x_o,
  output logic [11:0]      pointer_y_o,
  output logic             used_random_o
);
  import bcp_pkg::*;

  localparam int unsigned HalfW = DIM_W - 1;

  logic [MomW-1:0]  x_mom_q, y_mom_q;
  logic [TotW-1:0]  tot_q;
  logic [CNT_W-1:0] col_q, row_q;
  logic [15:0]      lfsr_q;
  logic [RemW-1:0]  rem_q;
  logic [NumW-1:0]  quo_q;
  logic signed [OffW-1:0] vx_q, vy_q;
  logic [M2W-1:0]   sq_q, m2_q, sv_q, res_q, bit_q;
  logic signed [DirW-1:0] ux_q, uy_q;
  logic signed [CorW-1:0] cx_q, cy_q;
  logic signed [AngW-1:0] cz_q;
  logic             neg_q, rnd_q;

  // pixel accumulate
  logic [9:0]         sum;
  logic [CNT_W+9:0]   xprod, yprod;
  logic               row_wrap, col_wrap;
  logic [HalfW-1:0]   hw, hh, rr;
  logic [DIM_W-1:0]   dmin;

  assign sum   = 10'(red_i) + 10'(green_i) + 10'(blue_i);
  assign xprod = col_q * sum;
  assign yprod = row_q * sum;
  assign row_wrap = !((DIM_W+1)'(row_q) + (DIM_W+1)'(1) < (DIM_W+1)'(height_i));
  assign col_wrap = !((DIM_W+1)'(col_q) + (DIM_W+1)'(1) < (DIM_W+1)'(width_i));
  assign hw   = width_i[DIM_W-1:1];
  assign hh   = height_i[DIM_W-1:1];
  assign dmin = (width_i < height_i) ? width_i : height_i;
  assign rr   = dmin[DIM_W-1:1];

  // divider step
  logic [RemW-1:0] rem_sh, rem_sub;
  logic [RemW-1:0] den_q;
  logic            ge;
  assign rem_sh  = {rem_q[RemW-2:0], quo_q[NumW-1]};
  assign ge      = rem_sh >= den_q;
  assign rem_sub = rem_sh - den_q;

  // quotient saturations
  logic [25:0] cent;
  logic signed [OffW-1:0] off_x, off_y;
  logic [8:0]  unit;
  assign cent  = (quo_q > NumW'(1 << 25)) ? 26'(1 << 25) : quo_q[25:0];
  assign off_x = $signed(OffW'(cent)) - $signed(OffW'({hw, 8'b0}));
  assign off_y = $signed(OffW'(cent)) - $signed(OffW'({hh, 8'b0}));
  assign unit  = (quo_q > NumW'(256)) ? 9'd256 : quo_q[8:0];

  logic [OffW-1:0] ax, ay;
  assign ax = vx_q[OffW-1] ? OffW'(-vx_q) : OffW'(vx_q);
  assign ay = vy_q[OffW-1] ? OffW'(-vy_q) : OffW'(vy_q);

  logic signed [2*OffW-1:0] sqp;
  assign sqp = (cmd_i.op == CMD_SQ1) ? vx_q * vx_q : vy_q * vy_q;

  logic [15:0] dz2;
  assign dz2 = dead_zone_i * dead_zone_i;

  // square root step
  logic [M2W-1:0] rb;
  assign rb = res_q + bit_q;

  // LFSR advance and phase fold
  logic [15:0] lfsr_sh, lfsr_nx;
  logic [16:0] ang;
  logic        phase_neg;
  assign lfsr_sh   = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrMask : 16'h0);
  assign lfsr_nx   = (lfsr_sh == 16'h0) ? 16'h1 : lfsr_sh;
  assign phase_neg = lfsr_nx > 16'h8000;
  assign ang = phase_neg ? 17'h10000 - 17'(lfsr_nx) : 17'(lfsr_nx);

  // CORDIC step
  logic signed [CorW-1:0] xs, ys;
  logic signed [AngW-1:0] at;
  assign xs = cx_q >>> cmd_i.idx;
  assign ys = cy_q >>> cmd_i.idx;
  assign at = $signed(atan_q14(cmd_i.idx));

  logic signed [CorW-1:0] sr, cr;
  logic signed [DirW-1:0] sdir, cdir;
  assign sr = (cy_q + CorW'(32)) >>> 6;
  assign cr = (cx_q + CorW'(32)) >>> 6;
  assign sdir = (sr > CorW'(256)) ? DirW'(256) :
                (sr < -CorW'(256)) ? -DirW'(256) : DirW'(sr);
  assign cdir = (cr > CorW'(256)) ? DirW'(256) :
                (cr < -CorW'(256)) ? -DirW'(256) : DirW'(cr);

  // placement
  localparam int unsigned PlW = 28;
  logic signed [PlW-1:0] tx, ty;
  assign tx = $signed(PlW'({hw, 8'b0})) + PlW'(ux_q) * $signed(PlW'(rr));
  assign ty = $signed(PlW'({hh, 8'b0})) + PlW'(uy_q) * $signed(PlW'(rr));

  function automatic logic [11:0] sat_place(input logic signed [PlW-1:0] t);
    logic [PlW-9:0] p;
    p = t[PlW-1:8];
    if (t[PlW-1]) return 12'd0;
    if (p > (PlW-8)'(4095)) return 12'd4095;
    return p[11:0];
  endfunction

  assign pointer_x_o   = sat_place(tx);
  assign pointer_y_o   = sat_place(ty);
  assign used_random_o = rnd_q;

  assign sts_o.frame_end  = row_wrap && col_wrap;
  assign sts_o.total_zero = (tot_q == '0);
  assign sts_o.below_dz   = m2_q < M2W'({dz2, 16'b0});
  assign sts_o.mag_zero   = (res_q[MagW-1:0] == '0);

  // counters, moments and LFSR
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_mom_q <= '0;
      y_mom_q <= '0;
      tot_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      lfsr_q  <= 16'h1;
    end else begin
      if (seed_we_i) begin
        lfsr_q <= (seed_i == 16'h0) ? 16'h1 : seed_i;
      end else if (cmd_i.op == CMD_RND_LD) begin
        lfsr_q <= lfsr_nx;
      end
      if (cmd_i.op == CMD_ACC) begin
        x_mom_q <= x_mom_q + MomW'(xprod);
        y_mom_q <= y_mom_q + MomW'(yprod);
        tot_q   <= tot_q + TotW'(sum);
        if (row_wrap) begin
          row_q <= '0;
          col_q <= col_wrap ? '0 : col_q + CNT_W'(1);
        end else begin
          row_q <= row_q + CNT_W'(1);
        end
      end else if (cmd_i.op == CMD_PLACE) begin
        x_mom_q <= '0;
        y_mom_q <= '0;
        tot_q   <= '0;
      end
    end
  end

  // end-of-frame arithmetic
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_DIV_LDX: begin
        rem_q <= '0; den_q <= RemW'(tot_q); quo_q <= {x_mom_q, 8'b0}; rnd_q <= 1'b0;
      end
      CMD_DIV_LDY: begin
        rem_q <= '0; den_q <= RemW'(tot_q); quo_q <= {y_mom_q, 8'b0};
      end
      CMD_DIV_LDUX: begin
        rem_q <= '0; den_q <= RemW'(res_q[MagW-1:0]); quo_q <= NumW'({ax, 8'b0});
      end
      CMD_DIV_LDUY: begin
        rem_q <= '0; den_q <= RemW'(res_q[MagW-1:0]); quo_q <= NumW'({ay, 8'b0});
      end
      CMD_DIV_STEP: begin
        rem_q <= ge ? rem_sub : rem_sh;
        quo_q <= {quo_q[NumW-2:0], ge};
      end
      CMD_ST_VX: vx_q <= off_x;
      CMD_ST_VY: vy_q <= off_y;
      CMD_SQ1: sq_q <= M2W'(sqp);
      CMD_SQ2: m2_q <= sq_q + M2W'(sqp);
      CMD_SQRT_LD: begin
        sv_q <= m2_q; res_q <= '0; bit_q <= M2W'(1) << (M2W - 1);
      end
      CMD_SQRT_STEP: begin
        if (sv_q >= rb) begin
          sv_q  <= sv_q - rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      CMD_ST_UX: ux_q <= vx_q[OffW-1] ? -DirW'(unit) : DirW'(unit);
      CMD_ST_UY: uy_q <= vy_q[OffW-1] ? -DirW'(unit) : DirW'(unit);
      CMD_RND_LD: begin
        cx_q <= CorX0; cy_q <= '0; cz_q <= AngW'(ang); neg_q <= phase_neg; rnd_q <= 1'b1;
      end
      CMD_COR_STEP: begin
        if (!cz_q[AngW-1]) begin
          cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
        end
      end
      CMD_ST_RDIR: begin
        ux_q <= sdir;
        uy_q <= neg_q ? -cdir : cdir;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/brightness_centroid_pointer.sv =====
// brightness_centroid_pointer: top level; configuration registers, result register
// and the controller/datapath pair. Depends on bcp_pkg, bcp_ctrl, bcp_datapath.
//
// Takes RGB pixels one word per cycle, column-major (rows inner), and after the
// last pixel of a frame emits one pointer word: frame center plus a unit vector
// toward the brightness centroid, scaled by half the smaller frame side. When
// the centroid lies within dead_zone pixels of the center, or the frame is
// black, the direction comes from an LFSR-driven phase instead and tuser is set.
// Pixels within a frame are taken at one per cycle. After the last pixel the
// block stops taking pixels while one restoring divider (one quotient bit per
// cycle) and a bit-pair square root run, or a CORDIC for the LFSR phase, which
// is also used when the offset length is zero; then it places the result. A
// finished word waits in its output register; placing waits until that
// register is free, and the next frame starts once the result is placed.
module brightness_centroid_pointer #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red, green, blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pointer_x, pointer_y
  output logic        m_axis_tuser,   // used_random
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import bcp_pkg::*;

  localparam int unsigned CntW_ = $clog2(MAX_DIM);
  localparam int unsigned DimW  = $clog2(MAX_DIM + 1);
  localparam logic [16:0] DimMax = 17'(MAX_DIM);

  logic [DimCfgW-1:0] width_q, height_q;
  logic [7:0]         dz_q;
  logic [DimW-1:0]    width_c, height_c;
  logic               seed_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimCfgW'(640);
      height_q <= DimCfgW'(480);
      dz_q     <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:     width_q  <= cfg_data_i[DimCfgW-1:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[DimCfgW-1:0];
        CFG_DEAD_ZONE: dz_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign seed_we = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_SEED);

  // clamp sizes to [1, MAX_DIM]
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimCfgW-1:0] v);
    logic [16:0] e;
    e = 17'(v);
    if (e == 17'd0) return DimW'(1);
    if (e > DimMax) return DimW'(DimMax);
    return DimW'(e);
  endfunction

  assign width_c  = clamp_dim(width_q);
  assign height_c = clamp_dim(height_q);

  cmd_t cmd;
  sts_t sts;
  logic out_free;
  logic [11:0] px, py;
  logic rnd;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  bcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bcp_datapath #(
    .CNT_W (CntW_),
    .DIM_W (DimW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .red_i         (s_axis_tdata[7:0]),
    .green_i       (s_axis_tdata[15:8]),
    .blue_i        (s_axis_tdata[23:16]),
    .width_i       (width_c),
    .height_i      (height_c),
    .dead_zone_i   (dz_q),
    .seed_we_i     (seed_we),
    .seed_i        (cfg_data_i),
    .pointer_x_o   (px),
    .pointer_y_o   (py),
    .used_random_o (rnd)
  );

  // result register: hold the word until taken
  logic out_load;
  assign out_load = (cmd.op == CMD_PLACE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {py, px};
      m_axis_tuser <= rnd;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before taken");

  a_no_accept_while_placing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !out_load)
    else $error("pixel taken during placement");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not shown");

endmodule
